// ===== rtl/core/sorted_key_table_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_key_table_macros.svh
// Assertion macros for the sorted key table RTL. They sample on the
// rising edge of clock and are off while reset is high.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds.
`define SKT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sorted_key_table: property failed");
// Check that a condition never occurs.
`define SKT_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("sorted_key_table: forbidden condition seen");
`else
`define SKT_ASSERT(label, prop)
`define SKT_ASSERT_NEVER(label, expr)
`endif
`endif

// ===== rtl/core/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Types and constants of the sorted key table: operation and status codes,
// cell commands and the control bundle sent down the cell row.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int CAPACITY_DEFAULT  = 16;
   localparam int KEY_WIDTH_DEFAULT = 32;
   localparam int PORT_KEY_WIDTH    = 32;

   typedef enum logic [1:0] {
      OP_INSERT    = 2'd0,
      OP_DELETE    = 2'd1,
      OP_DUMP_ASC  = 2'd2,
      OP_DUMP_DESC = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROT_LEFT,
      CELL_ROT_RIGHT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         cmp_signed;
   } cell_ctl_type;

endpackage

// ===== rtl/core/skt_cell.sv =====
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the sorted row: holds a key, compares it with the operand key
// and takes its next key from itself, a neighbor, the operand or the wrap.
// ----------------------------------------------------------------------------
module skt_cell #(
   parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  skt_pkg::cell_ctl_type ctl,
   input  logic [KEY_WIDTH-1:0]  op_key,
   input  logic                  occupied,
   input  logic                  is_last,
   input  logic                  left_seen,
   input  logic [KEY_WIDTH-1:0]  left_key,
   input  logic [KEY_WIDTH-1:0]  right_key,
   input  logic [KEY_WIDTH-1:0]  wrap_key,
   output logic [KEY_WIDTH-1:0]  key,
   output logic                  seen,
   output logic                  match
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic [KEY_WIDTH-1:0] own_ord;
   logic [KEY_WIDTH-1:0] op_ord;
   logic                 lt;

   // flip the sign bit so an unsigned compare gives the signed order
   assign own_ord = {key_ff[KEY_WIDTH-1] ^ ctl.cmp_signed, key_ff[KEY_WIDTH-2:0]};
   assign op_ord  = {op_key[KEY_WIDTH-1] ^ ctl.cmp_signed, op_key[KEY_WIDTH-2:0]};

   assign lt    = occupied && (own_ord < op_ord);
   assign match = occupied && (key_ff == op_key);
   assign key   = key_ff;

   // set from the first cell that starts the shift (insert point or first
   // matching key) through the rest of the row
   assign seen  = left_seen || ((ctl.cmd == skt_pkg::CELL_DELETE) ? match : !lt);

   always_comb begin
      key_in = key_ff;
      case (ctl.cmd)
         skt_pkg::CELL_HOLD:      key_in = key_ff;
         skt_pkg::CELL_INSERT: begin
            if (left_seen) key_in = left_key;
            else if (!lt)  key_in = op_key;
         end
         skt_pkg::CELL_DELETE:    if (seen) key_in = right_key;
         skt_pkg::CELL_ROT_LEFT:  key_in = is_last ? wrap_key : right_key;
         skt_pkg::CELL_ROT_RIGHT: key_in = left_key;
         default:                 key_in = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== rtl/core/skt_cell_row.sv =====
// ----------------------------------------------------------------------------
// skt_cell_row
// Row of CAPACITY cells chained left to right. Decodes the fill count into
// per-cell occupancy and picks out the head and tail keys.
// ----------------------------------------------------------------------------
module skt_cell_row #(
   parameter int CAPACITY  = skt_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEFAULT,
   localparam int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  skt_pkg::cell_ctl_type ctl,
   input  logic [KEY_WIDTH-1:0]  op_key,
   input  logic [CW-1:0]         count,
   output logic [KEY_WIDTH-1:0]  head_key,
   output logic [KEY_WIDTH-1:0]  tail_key,
   output logic                  found
);

   logic [KEY_WIDTH-1:0] keys [CAPACITY];
   logic [CAPACITY-1:0]  occ;
   logic [CAPACITY-1:0]  last;
   logic [CAPACITY-1:0]  seens;
   logic [CAPACITY-1:0]  hits;

   // tail = key of the highest occupied cell, one-hot AND-OR select
   always_comb begin
      tail_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (last[i]) tail_key = tail_key | keys[i];
      end
   end

   assign head_key = keys[0];
   assign found    = |hits;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      assign occ[g]  = CW'(g) < count;
      assign last[g] = CW'(g + 1) == count;

      skt_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .op_key    (op_key),
         .occupied  (occ[g]),
         .is_last   (last[g]),
         .left_seen ((g == 0) ? 1'b0 : seens[(g == 0) ? 0 : g - 1]),
         .left_key  ((g == 0) ? tail_key : keys[(g == 0) ? 0 : g - 1]),
         .right_key ((g == CAPACITY - 1) ? keys[0]
                                         : keys[(g == CAPACITY - 1) ? 0 : g + 1]),
         .wrap_key  (keys[0]),
         .key       (keys[g]),
         .seen      (seens[g]),
         .match     (hits[g])
      );
   end

endmodule

// ===== rtl/core/sorted_key_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted key table: up to CAPACITY keys kept in ascending order in a row of
// cells, with insert, delete by key and ascending or descending dump.
// ----------------------------------------------------------------------------
// Insert and delete each register the request, then take one step in which
// every cell compares against the key and shifts or holds in parallel. A
// dump of n keys rotates the row by one cell per cycle while the output is
// not stalled and shows one key per cycle at its head (ascending) or its
// tail (descending); after n rotations the row is back in place.
// A full insert, a delete on an empty table or with no match, and a dump of
// an empty table give a single result with the matching status. One item
// is in work at a time; the next request is taken once the last result of
// the current one sits in the output register. Output stall slows the dump
// and holds the cell step of the next item until the previous result has
// been taken. compare_signed selects signed or unsigned ordering and must
// only be written while the table is idle; a key inserted under one ordering
// stays where it was put if the ordering changes later.
// ----------------------------------------------------------------------------
module sorted_key_table #(
   parameter int CAPACITY  = skt_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_key_value,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_element_value,
   output logic        rsp_last_result,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_compare_signed
);

   `include "sorted_key_table_macros.svh"

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = skt_pkg::PORT_KEY_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DUMP
   } state_type;

   state_type             state_ff,   state_in;
   skt_pkg::op_type       op_ff,      op_in;
   logic [KEY_WIDTH-1:0]  key_ff,     key_in;
   logic [CW-1:0]         count_ff,   count_in;
   logic [CW-1:0]         dump_idx_ff, dump_idx_in;
   logic                  signed_ff,  signed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   skt_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [KEY_WIDTH-1:0]  rsp_key_ff,   rsp_key_in;
   logic                  rsp_last_ff,  rsp_last_in;

   logic                  req_xfer;
   logic                  rsp_free;
   logic [KEY_WIDTH-1:0]  req_key;
   skt_pkg::cell_ctl_type ctl;
   logic [KEY_WIDTH-1:0]  head_key;
   logic [KEY_WIDTH-1:0]  tail_key;
   logic                  found;

   // take the key in its low KEY_WIDTH bits (zero-extended if wider), fit the result to the port
   if (KEY_WIDTH <= PW) begin : g_narrow
      assign req_key           = req_key_value[KEY_WIDTH-1:0];
      assign rsp_element_value = PW'(rsp_key_ff);
   end else begin : g_wide
      assign req_key           = KEY_WIDTH'(req_key_value);
      assign rsp_element_value = rsp_key_ff[PW-1:0];
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign req_xfer        = req_valid && !req_stall;
   assign rsp_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_result = rsp_last_ff;
   assign csr_ready       = 1'b1;

   skt_cell_row #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_row (
      .clock    (clock),
      .ctl      (ctl),
      .op_key   (key_ff),
      .count    (count_ff),
      .head_key (head_key),
      .tail_key (tail_key),
      .found    (found)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      dump_idx_in   = dump_idx_ff;
      signed_in     = signed_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_last_in   = rsp_last_ff;
      ctl.cmd        = skt_pkg::CELL_HOLD;
      ctl.cmp_signed = signed_ff;

      // register write, to be done only while idle: the user keeps to this, the block itself does not enforce it
      if (csr_valid && csr_ready) signed_in = csr_compare_signed;

      case (state_ff)
         S_IDLE: begin
            // capture the request for the cell step
            if (req_xfer) begin
               op_in    = skt_pkg::op_type'(req_operation);
               key_in   = req_key;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait for room in the output register, then step the row or start the dump
            if (rsp_free) begin
               rsp_key_in  = '0;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
               case (op_ff)
                  skt_pkg::OP_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        rsp_status_in = skt_pkg::ST_FULL;
                     end else begin
                        ctl.cmd       = skt_pkg::CELL_INSERT;
                        count_in      = CW'(count_ff + 1'b1);
                        rsp_status_in = skt_pkg::ST_OK;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  skt_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = skt_pkg::ST_EMPTY;
                     end else if (!found) begin
                        rsp_status_in = skt_pkg::ST_NOT_FOUND;
                     end else begin
                        ctl.cmd       = skt_pkg::CELL_DELETE;
                        count_in      = CW'(count_ff - 1'b1);
                        rsp_status_in = skt_pkg::ST_OK;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     // dump: an empty table answers at once
                     if (count_ff == '0) begin
                        rsp_status_in = skt_pkg::ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        dump_idx_in = '0;
                        state_in    = S_DUMP;
                     end
                  end
               endcase
            end
         end
         S_DUMP: begin
            // show one key per transfer slot and rotate the row by one cell
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = skt_pkg::ST_OK;
               if (op_ff == skt_pkg::OP_DUMP_ASC) begin
                  rsp_key_in = head_key;
                  ctl.cmd    = skt_pkg::CELL_ROT_LEFT;
               end else begin
                  rsp_key_in = tail_key;
                  ctl.cmd    = skt_pkg::CELL_ROT_RIGHT;
               end
               rsp_last_in = (dump_idx_ff == CW'(count_ff - 1'b1));
               dump_idx_in = CW'(dump_idx_ff + 1'b1);
               if (rsp_last_in) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         signed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         signed_ff    <= signed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // fill count stays within the row
   `SKT_ASSERT_NEVER(a_count_bound, count_ff > CW'(CAPACITY))
   // the fill count moves only out of the cell step
   `SKT_ASSERT(a_count_src, !$past(reset) && count_ff != $past(count_ff) |-> $past(state_ff == S_EXEC))
   // a dump only walks over stored keys
   `SKT_ASSERT(a_dump_idx, state_ff == S_DUMP |-> dump_idx_ff < count_ff)
   // a result is loaded only from the cell step or the dump walk
   `SKT_ASSERT(a_rsp_src, $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC) || $past(state_ff == S_DUMP))

endmodule

// ===== bench/sorted_key_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_checker
// Watches the request, result and configuration channels of the sorted key
// table, keeps its own copy of the table and compares every result transfer.
// ----------------------------------------------------------------------------
module sorted_key_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_key_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_element_value,
   input  logic        rsp_last_result,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_compare_signed,
   output int          fail_count,
   output int          pending,
   output int          results_checked,
   output int          full_seen,
   output int          empty_seen
);

   import skt_pkg::*;

   localparam int TABLE_DEPTH = CAPACITY_DEFAULT;

   typedef struct packed {
      status_type  status;
      logic [31:0] element;
      logic        last;
   } table_result_t;

   logic [31:0]   stored_keys [TABLE_DEPTH];
   int            key_count;
   logic          order_signed;
   table_result_t expected_results [$];

   // Flip the sign bit so an unsigned compare gives the signed order.
   function automatic logic [31:0] order_of(input logic [31:0] key);
      return order_signed ? (key ^ 32'h8000_0000) : key;
   endfunction

   task automatic queue_result(input status_type st, input logic [31:0] value,
                               input logic last);
      table_result_t r;
      r.status  = st;
      r.element = value;
      r.last    = last;
      expected_results.push_back(r);
   endtask

   task automatic apply_request(input op_type op, input logic [31:0] key);
      int pos;
      int idx;
      int src;
      pos = 0;
      case (op)
         OP_INSERT: begin
            if (key_count >= TABLE_DEPTH) begin
               queue_result(ST_FULL, '0, 1'b1);
            end else begin
               // land in front of any equal keys
               while (pos < key_count && order_of(stored_keys[pos]) < order_of(key))
                  pos++;
               for (idx = key_count; idx > pos; idx--)
                  stored_keys[idx] = stored_keys[idx - 1];
               stored_keys[pos] = key;
               key_count++;
               queue_result(ST_OK, '0, 1'b1);
            end
         end
         OP_DELETE: begin
            if (key_count == 0) begin
               queue_result(ST_EMPTY, '0, 1'b1);
            end else begin
               while (pos < key_count && stored_keys[pos] != key)
                  pos++;
               if (pos >= key_count) begin
                  queue_result(ST_NOT_FOUND, '0, 1'b1);
               end else begin
                  for (idx = pos; idx + 1 < key_count; idx++)
                     stored_keys[idx] = stored_keys[idx + 1];
                  key_count--;
                  queue_result(ST_OK, '0, 1'b1);
               end
            end
         end
         default: begin
            if (key_count == 0) begin
               queue_result(ST_EMPTY, '0, 1'b1);
            end else begin
               for (idx = 0; idx < key_count; idx++) begin
                  src = (op == OP_DUMP_ASC) ? idx : key_count - 1 - idx;
                  queue_result(ST_OK, stored_keys[src], idx == key_count - 1);
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : monitor
      table_result_t want;
      if (reset) begin
         key_count       = 0;
         order_signed    = 1'b0;
         expected_results.delete();
         fail_count      = 0;
         results_checked = 0;
         full_seen       = 0;
         empty_seen      = 0;
      end else begin
         // Compare first: a request taken on this edge cannot own this result.
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (rsp_status == ST_FULL)  full_seen++;
            if (rsp_status == ST_EMPTY) empty_seen++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with none expected: status %0d value %h last %0d",
                           $realtime, rsp_status, rsp_element_value, rsp_last_result);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status || rsp_element_value !== want.element ||
                   rsp_last_result !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: result %0d expected status %0d value %h last %0d, got status %0d value %h last %0d",
                              $realtime, results_checked, want.status, want.element,
                              want.last, rsp_status, rsp_element_value, rsp_last_result);
               end
            end
         end
         if (csr_valid && csr_ready)
            order_signed = csr_compare_signed;
         if (req_valid && !req_stall)
            apply_request(op_type'(req_operation), req_key_value);
      end
      pending = expected_results.size();
   end

endmodule

// ===== bench/sorted_key_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// Drives insert, delete and dump requests into the sorted key table under
// both key orderings, with random gaps and result stalls; the checker next
// to the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;

   import skt_pkg::*;

   localparam int TABLE_DEPTH    = CAPACITY_DEFAULT;
   localparam int PHASE_COUNT    = 6;
   localparam int ITEMS_PER_PHASE = 76;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [31:0] req_key_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_element_value;
   logic        rsp_last_result;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_compare_signed;

   int          fail_count;
   int          pending;
   int          results_checked;
   int          full_seen;
   int          empty_seen;

   // requests sent, per operation code
   int          ops_sent [4];
   // when set, neither side inserts gaps or stalls
   bit          calm;
   // small key pool so that deletes hit and duplicates pile up
   logic [31:0] key_pool [8];

   sorted_key_table #(
      .CAPACITY  (TABLE_DEPTH),
      .KEY_WIDTH (KEY_WIDTH_DEFAULT)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_key_value      (req_key_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_element_value  (rsp_element_value),
      .rsp_last_result    (rsp_last_result),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_compare_signed (csr_compare_signed)
   );

   sorted_key_table_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_key_value      (req_key_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_element_value  (rsp_element_value),
      .rsp_last_result    (rsp_last_result),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_compare_signed (csr_compare_signed),
      .fail_count         (fail_count),
      .pending            (pending),
      .results_checked    (results_checked),
      .full_seen          (full_seen),
      .empty_seen         (empty_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop: the slowest legal run (every item a full dump, every
   // result stalled as long as the result side allows) stays far below this.
   initial begin
      #10_000_000;
      $display("timeout: handshake never completed");
      $display("sorted_key_table regression: fail");
      $finish;
   end

   // Result side: before each transfer, raise stall for a randomly drawn
   // hold. A zero draw keeps stall low, so it is never lowered and raised
   // in the same step.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Send one request: idle for a random gap, then hold valid and payload
   // until the transfer. Enter and leave on a falling edge.
   task automatic send(input op_type op, input logic [31:0] key);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key_value <= key;
      ops_sent[int'(op)]++;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic wait_drained;
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_order(input logic signed_order);
      csr_valid          <= 1'b1;
      csr_compare_signed <= signed_order;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int          phase;
      int          item;
      int          roll;
      int          insert_pct;
      op_type      op;
      logic [31:0] key;

      reset              = 1'b1;
      req_valid          = 1'b0;
      req_operation      = OP_INSERT;
      req_key_value      = '0;
      csr_valid          = 1'b0;
      csr_compare_signed = 1'b0;
      calm               = 1'b0;
      foreach (ops_sent[i]) ops_sent[i] = 0;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: unsigned order, empty-table cases, key extremes,
      // duplicates, a miss and a hit on delete, both dumps, then fill up
      // and push one insert past capacity.
      write_order(1'b0);
      send(OP_DUMP_ASC,  32'hFFFF_FFFF);
      send(OP_DUMP_DESC, 32'h0000_0000);
      send(OP_DELETE,    32'h0000_0000);
      send(OP_INSERT,    32'h0000_0000);
      send(OP_INSERT,    32'hFFFF_FFFF);
      send(OP_INSERT,    32'h8000_0000);
      send(OP_INSERT,    32'h7FFF_FFFF);
      send(OP_INSERT,    32'h0000_0001);
      send(OP_INSERT,    32'h7FFF_FFFF);
      send(OP_DELETE,    32'h1234_5678);
      send(OP_DELETE,    32'h7FFF_FFFF);
      send(OP_DUMP_ASC,  $urandom());
      send(OP_DUMP_DESC, $urandom());
      repeat (11) send(OP_INSERT, $urandom());
      send(OP_INSERT, 32'h5555_AAAA);

      // Random phases: alternate the ordering and cycle through draining,
      // filling and balanced mixes so both full and empty are reached
      // under each ordering.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         write_order(phase % 2 == 0);
         case (phase % 3)
            0:       insert_pct = 20;
            1:       insert_pct = 60;
            default: insert_pct = 40;
         endcase
         key_pool[0] = 32'h0000_0000;
         key_pool[1] = 32'hFFFF_FFFF;
         key_pool[2] = 32'h8000_0000;
         key_pool[3] = 32'h7FFF_FFFF;
         for (int i = 4; i < 8; i++) key_pool[i] = $urandom();

         for (item = 0; item < ITEMS_PER_PHASE; item++) begin
            // re-roll the idle mode every 16 requests
            if (item % 16 == 0) calm = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < insert_pct)  op = OP_INSERT;
            else if (roll < 75)     op = OP_DELETE;
            else if (roll < 88)     op = OP_DUMP_ASC;
            else                    op = OP_DUMP_DESC;
            if ($urandom_range(0, 9) < 7) key = key_pool[$urandom_range(0, 7)];
            else                          key = $urandom();
            send(op, key);
         end
      end

      // Drain, then leave room for any stray result of a full-size dump.
      calm = 1'b0;
      wait_drained();
      repeat (TABLE_DEPTH + 4) @(negedge clock);

      $display("covered %0d requests: %0d insert, %0d delete, %0d dump, both key orders",
               ops_sent[0] + ops_sent[1] + ops_sent[2] + ops_sent[3], ops_sent[0],
               ops_sent[1], ops_sent[2] + ops_sent[3]);
      $display("checked %0d results, %0d table-full and %0d table-empty among them",
               results_checked, full_seen, empty_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("sorted_key_table regression: pass");
      end else begin
         $display("sorted_key_table regression: fail");
      end
      $finish;
   end

endmodule
